FILE: design/mma_pkg.sv
// Shared types and constants for the multichannel moving average.
// Depends on nothing; every other file of the block but mma_window_ram uses it.
package mma_pkg;

    // Default sizing of the block.
    localparam int DEF_CHANNELS    = 4;
    localparam int DEF_WINDOW_LEN  = 8;
    localparam int DEF_SAMPLE_BITS = 12;

    // Fixed port widths.
    localparam int SAMPLE_W  = 12;
    localparam int CHANNEL_W = 2;
    localparam int AVERAGE_W = 12;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WRITE = 6'b000010,
        ST_SUM   = 6'b000100,
        ST_LAST  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    // Operation select for the shared accumulate/divide unit.
    typedef struct packed {
        logic clr;
        logic add;
        logic div_step;
    } t_dp_ctl;

endpackage

FILE: design/mma_window_ram.sv
// Sample window storage: one write port and one registered read port.
// Depends on nothing.
module mma_window_ram #(
    parameter int DATA_W = 12,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mma_accum_div.sv
// Shared arithmetic unit: accumulates a window and then divides the sum
// by the window length with one reciprocal multiplication. Uses mma_pkg.
module mma_accum_div #(
    parameter int WINDOW_LEN  = mma_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = mma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  mma_pkg::t_dp_ctl       i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_rdata,
    output logic [SAMPLE_BITS-1:0] o_quotient
);
    import mma_pkg::*;

    localparam int SL_W   = $clog2(WINDOW_LEN);
    localparam int SUM_W  = SAMPLE_BITS + SL_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam int SHIFT  = SUM_W + SL_W;

    // Rounded-up reciprocal of the window length. With SHIFT chosen as the
    // sum width plus the bits of the window length, the top bits of the
    // product give the exact truncated quotient for every possible sum.
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

    logic [SUM_W-1:0]  r_acc, n_acc;
    logic [PROD_W-1:0] product;

    // The multiplier is SUM_W by RCP_W bits; the upper operand bits are zero.
    always_comb begin
        product = PROD_W'(r_acc) * PROD_W'(RECIP);
        n_acc   = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.add) begin
            n_acc = r_acc + SUM_W'(i_rdata);
        end else if (i_ctl.div_step) begin
            n_acc = SUM_W'(product >> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_quotient = r_acc[SAMPLE_BITS-1:0];

endmodule

FILE: design/mma_ctrl.sv
// Sequencer: stores each word, and at the end of a round walks every
// channel's window through the shared unit. Uses mma_pkg.
module mma_ctrl #(
    parameter int CHANNELS    = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW_LEN  = mma_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = mma_pkg::DEF_SAMPLE_BITS,
    parameter int CH_W        = 2,
    parameter int SL_W        = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CH_W-1:0]        o_k,
    output logic                   o_last,
    output logic                   o_we,
    output logic [CH_W+SL_W-1:0]   o_waddr,
    output logic [SAMPLE_BITS-1:0] o_wdata,
    output logic [CH_W+SL_W-1:0]   o_raddr,
    output mma_pkg::t_dp_ctl       o_ctl
);
    import mma_pkg::*;

    t_state                 r_state, n_state;
    logic [CH_W-1:0]        r_ch, n_ch;
    logic [CH_W-1:0]        r_k, n_k;
    logic [SL_W-1:0]        r_slot, n_slot;
    logic [SL_W-1:0]        r_idx, n_idx;
    logic                   r_first, n_first;
    logic                   r_rdv, n_rdv;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic                   k_last;

    assign k_last = r_k == CH_W'(CHANNELS - 1);

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_k      = r_k;
        n_slot   = r_slot;
        n_idx    = r_idx;
        n_first  = r_first;
        n_rdv    = r_rdv;
        n_sample = r_sample;
        o_ctl    = '0;
        o_we     = 1'b0;
        o_waddr  = {r_ch, (r_first ? r_idx : r_slot)};
        o_raddr  = {r_k, r_idx};
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_sample = i_sample;
                    n_idx    = '0;
                    n_state  = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_we = 1'b1;
                if (r_first && r_idx != SL_W'(WINDOW_LEN - 1)) begin
                    n_idx = SL_W'(r_idx + 1'b1);
                end else if (r_ch == CH_W'(CHANNELS - 1)) begin
                    n_ch      = '0;
                    n_slot    = (r_slot == SL_W'(WINDOW_LEN - 1)) ? '0
                                                                  : SL_W'(r_slot + 1'b1);
                    n_first   = 1'b0;
                    n_k       = '0;
                    n_idx     = '0;
                    n_rdv     = 1'b0;
                    o_ctl.clr = 1'b1;
                    n_state   = ST_SUM;
                end else begin
                    n_ch    = CH_W'(r_ch + 1'b1);
                    n_state = ST_IDLE;
                end
            end
            ST_SUM: begin
                o_ctl.add = r_rdv;
                n_rdv     = 1'b1;
                n_idx     = SL_W'(r_idx + 1'b1);
                if (r_idx == SL_W'(WINDOW_LEN - 1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                o_ctl.add = 1'b1;
                n_rdv     = 1'b0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    if (k_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k       = CH_W'(r_k + 1'b1);
                        n_idx     = '0;
                        o_ctl.clr = 1'b1;
                        n_state   = ST_SUM;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
            r_k     <= '0;
            r_slot  <= '0;
            r_idx   <= '0;
            r_first <= 1'b1;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_k     <= n_k;
            r_slot  <= n_slot;
            r_idx   <= n_idx;
            r_first <= n_first;
            r_rdv   <= n_rdv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    assign o_stall = r_state != ST_IDLE;
    assign o_valid = r_state == ST_OUT;
    assign o_k     = r_k;
    assign o_last  = k_last;
    assign o_wdata = r_sample;

endmodule

FILE: design/multichannel_moving_average.sv
// Top level of the round-robin multichannel boxcar moving average.
// Depends on mma_pkg, mma_window_ram, mma_accum_div and mma_ctrl.
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_stall   i_sample
//  result    out        o_valid / i_stall   o_channel, o_average, o_last
//
// A mid-round word costs the accept cycle and one RAM write.
// During the first round a word writes every slot of its channel's window.
// The word that closes a round then, per channel, sums the window through
// the single RAM read port, divides the sum by the window length with one
// reciprocal multiplication, and hands over the result word.
// Reset is synchronous and clears the sequencer; the window RAM is not
// cleared, since every entry is written before the first read. o_stall is
// high whenever the block is busy, and a stalled result simply holds.
module multichannel_moving_average #(
    parameter int CHANNELS    = mma_pkg::DEF_CHANNELS,
    parameter int WINDOW_LEN  = mma_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = mma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [mma_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                           o_stall,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mma_pkg::CHANNEL_W-1:0]  o_channel,
    output logic [mma_pkg::AVERAGE_W-1:0]  o_average,
    output logic                           o_last
);
    import mma_pkg::*;

    // A single channel still needs one address bit for the counters.
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SL_W   = $clog2(WINDOW_LEN);
    localparam int ADDR_W = CH_W + SL_W;

    logic [SAMPLE_BITS-1:0] sample;
    logic [CH_W-1:0]        k;
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] quotient;
    t_dp_ctl                dp_ctl;

    // Only the low SAMPLE_BITS bits of a converter word are meaningful;
    // narrower words are zero-extended.
    assign sample = SAMPLE_BITS'(i_sample);

    mma_ctrl #(
        .CHANNELS    (CHANNELS),
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CH_W        (CH_W),
        .SL_W        (SL_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sample (sample),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_k      (k),
        .o_last   (o_last),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .o_ctl    (dp_ctl)
    );

    // Window storage is addressed as {channel, slot}.
    mma_window_ram #(
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mma_accum_div #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum_div (
        .i_clk      (i_clk),
        .i_ctl      (dp_ctl),
        .i_rdata    (rdata),
        .o_quotient (quotient)
    );

    // The channel index and the mean are reported in fixed-width fields;
    // wider values are truncated and narrower ones zero-extended.
    assign o_channel = CHANNEL_W'(k);
    assign o_average = AVERAGE_W'(quotient);

    // The block never takes a new sample while a result word is offered.
    a_no_accept_while_out : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall
    ) else $error("input accepted while a result is pending");

    // Handing over the final result of a round returns the block to idle.
    a_last_frees_input : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (!o_stall && !o_valid)
    ) else $error("block not idle after the last result of a round");

    // Every accepted sample occupies the block for at least its RAM write.
    a_accept_busies : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && !o_valid)
    ) else $error("accepted sample not followed by a write cycle");

    // A result that is not the last one is followed by summing, not output.
    a_next_channel_sums : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> (!o_valid && o_stall)
    ) else $error("next channel result issued without summing its window");

endmodule
